@@ design/rbms_pkg.sv @@
// ----------------------------------------------------------------------------
// rbms_pkg
// Shared types and constants for the rectangle bound mixed-radix split unit:
// register map, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package rbms_pkg;

   // Default number of sub-dimensions the stride table can hold.
   localparam int MAX_DIM_DEFAULT = 4;

   // Register file geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int BOUND_W    = 64;
   localparam int IDX_W      = 3;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_SPLIT_DIM   = 3'd0;
   localparam logic [2:0] REG_PART_COUNT  = 3'd1;
   localparam logic [2:0] REG_PART_SIZE_1 = 3'd2;
   localparam logic [2:0] REG_PART_SIZE_2 = 3'd3;
   localparam logic [2:0] REG_PART_SIZE_3 = 3'd4;

   typedef enum logic [3:0] {
      ST_RB_INIT,
      ST_RB_WRITE,
      ST_RB_MUL_LO,
      ST_RB_MUL_HI,
      ST_RB_ACC,
      ST_IDLE,
      ST_PASS,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PART_OUT
   } state_type;

   typedef struct packed {
      logic rb_init;
      logic rb_write;
      logic rb_mul_lo;
      logic rb_mul_hi;
      logic rb_acc;
      logic accept;
      logic load_pass;
      logic div_start;
      logic load_part;
   } cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic rb_last;
      logic split_hit;
      logic div_done;
      logic out_free;
      logic part_last;
   } status_type;

endpackage

`default_nettype wire

@@ design/rect_bound_mixed_radix_split_unit.sv @@
// ----------------------------------------------------------------------------
// rect_bound_mixed_radix_split_unit
// Splits one configured rectangle dimension into mixed-radix coordinates.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel one rectangle dimension at a time (low and
// high bound, plus a flag on the last dimension). Each item yields one result
// on the rsp_ channel, or part_count results when it is the split dimension
// (a count of zero acts as one, and counts above MAX_DIM are clipped to it).
// Settings are to be written through the csr_ port while the block is idle;
// the block itself leaves this to the user. A pass-through item is loaded
// into the result register from ST_PASS, the state after acceptance, once
// that register is free. A split item takes one round per coordinate: two
// 64-bit dividers run side by side at one quotient bit per cycle, framed by
// start, sign fix-up, wait and output steps. One item is worked on at a time;
// the next is taken once the last result of the current one sits in the
// output register.
// After reset, and after every configuration register write made while idle
// or rebuilding, the stride table is rebuilt with a 32-bit multiplier, during
// which no item is accepted. Reset clears the dimension counters and sets the
// registers to their defaults. While the receiver stalls, the result holds
// and the work stops at the next result until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_bound_mixed_radix_split_unit #(
   parameter int MAX_DIM = rbms_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rbms_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [rbms_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rbms_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready,
   // Input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [rbms_pkg::BOUND_W-1:0] req_lo_bound,
   input  wire logic signed [rbms_pkg::BOUND_W-1:0] req_hi_bound,
   input  wire logic                                req_rect_last,
   // Result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [rbms_pkg::IDX_W-1:0]               rsp_out_index,
   output logic signed [rbms_pkg::BOUND_W-1:0]      rsp_out_lo,
   output logic signed [rbms_pkg::BOUND_W-1:0]      rsp_out_hi,
   output logic                                     rsp_run_last
);

   rbms_pkg::cmd_type    cmd;
   rbms_pkg::status_type status;

   assign csr_pready = 1'b1;

   rbms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rbms_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .req_lo_bound  (req_lo_bound),
      .req_hi_bound  (req_hi_bound),
      .req_rect_last (req_rect_last),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_index (rsp_out_index),
      .rsp_out_lo    (rsp_out_lo),
      .rsp_out_hi    (rsp_out_hi),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

`default_nettype wire

@@ design/rbms_div.sv @@
// ----------------------------------------------------------------------------
// rbms_div
// Iterative signed 64-bit divider, one quotient bit per cycle. Quotient is
// truncated toward zero and the remainder takes the dividend's sign; a zero
// divisor gives a zero quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rbms_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [rbms_pkg::BOUND_W-1:0]     dividend,
   input  wire logic [rbms_pkg::BOUND_W-1:0]     divisor,
   output logic                                  done,
   output logic [rbms_pkg::BOUND_W-1:0]          quotient,
   output logic [rbms_pkg::BOUND_W-1:0]          remainder
);

   localparam int W    = rbms_pkg::BOUND_W;
   localparam int CW   = $clog2(W);

   logic          run_ff,   run_in;
   logic          fix_ff,   fix_in;
   logic          done_ff,  done_in;
   logic [CW-1:0] cnt_ff,   cnt_in;
   logic [W-1:0]  rem_ff,   rem_in;
   logic [W-1:0]  quo_ff,   quo_in;
   logic [W-1:0]  dsr_ff,   dsr_in;
   logic [W-1:0]  dvd_ff,   dvd_in;
   logic          negq_ff,  negq_in;
   logic          negr_ff,  negr_in;
   logic          zero_ff,  zero_in;
   logic [W-1:0]  q_ff,     q_in;
   logic [W-1:0]  r_ff,     r_in;

   logic [W:0]    shifted;
   logic [W:0]    trial;

   always_comb begin
      run_in  = run_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      zero_in = zero_ff;
      q_in    = q_ff;
      r_in    = r_ff;

      // For a nonzero divisor the partial remainder stays below the divisor
      // magnitude, so the shifted value never reaches the top bit of the trial subtraction.
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};

      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         dsr_in  = divisor[W-1] ? (~divisor + 1'b1) : divisor;
         dvd_in  = dividend;
         negq_in = dividend[W-1] ^ divisor[W-1];
         negr_in = dividend[W-1];
         zero_in = (divisor == '0);
      end else if (run_ff) begin
         if (trial[W]) begin
            rem_in = shifted[W-1:0];
         end else begin
            rem_in = trial[W-1:0];
         end
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            run_in = 1'b0;
            fix_in = 1'b1;
         end
      end else if (fix_ff) begin
         done_in = 1'b1;
         if (zero_ff) begin
            q_in = '0;
            r_in = dvd_ff;
         end else begin
            q_in = negq_ff ? (~quo_ff + 1'b1) : quo_ff;
            r_in = negr_ff ? (~rem_ff + 1'b1) : rem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      dvd_ff  <= dvd_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      zero_ff <= zero_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

`default_nettype wire

@@ design/rbms_dp.sv @@
// ----------------------------------------------------------------------------
// rbms_dp
// Datapath: configuration registers, stride table and its rebuild multiplier,
// dimension counters, the pair of dividers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbms_dp #(
   parameter int MAX_DIM = rbms_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire rbms_pkg::cmd_type                  cmd,
   output rbms_pkg::status_type                    status,
   // Register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [rbms_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [rbms_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rbms_pkg::CSR_DATA_W-1:0]         csr_prdata,
   // Input item
   input  wire logic signed [rbms_pkg::BOUND_W-1:0] req_lo_bound,
   input  wire logic signed [rbms_pkg::BOUND_W-1:0] req_hi_bound,
   input  wire logic                               req_rect_last,
   // Result item
   input  wire logic                               rsp_stall,
   output logic                                    rsp_valid,
   output logic [rbms_pkg::IDX_W-1:0]              rsp_out_index,
   output logic signed [rbms_pkg::BOUND_W-1:0]     rsp_out_lo,
   output logic signed [rbms_pkg::BOUND_W-1:0]     rsp_out_hi,
   output logic                                    rsp_run_last
);

   localparam int W    = rbms_pkg::BOUND_W;
   localparam int DW   = rbms_pkg::CSR_DATA_W;
   localparam int XW   = rbms_pkg::IDX_W;
   localparam int IDXW = $clog2(MAX_DIM);

   // Configuration registers.
   logic [1:0]    split_dim_ff,  split_dim_in;
   logic [2:0]    part_count_ff, part_count_in;
   logic [DW-1:0] part_size1_ff, part_size1_in;
   logic [DW-1:0] part_size2_ff, part_size2_in;
   logic [DW-1:0] part_size3_ff, part_size3_in;

   // Stride table and rebuild state.
   logic [W-1:0]    stride_ff [MAX_DIM];
   logic [W-1:0]    stride_in [MAX_DIM];
   logic [IDXW-1:0] rb_idx_ff, rb_idx_in;
   logic [W-1:0]    acc_ff,    acc_in;
   logic [W-1:0]    plo_ff,    plo_in;
   logic [DW-1:0]   phi_ff,    phi_in;

   // Item state.
   logic [W-1:0]    lo_ff,     lo_in;
   logic [W-1:0]    hi_ff,     hi_in;
   logic            last_ff,   last_in;
   logic [IDXW-1:0] part_ff,   part_in;
   logic [XW-1:0]   in_cnt_ff,  in_cnt_in;
   logic [XW-1:0]   out_cnt_ff, out_cnt_in;

   // Result register.
   logic            rv_ff,   rv_in;
   logic [XW-1:0]   ridx_ff, ridx_in;
   logic [W-1:0]    rlo_ff,  rlo_in;
   logic [W-1:0]    rhi_ff,  rhi_in;
   logic            rlast_ff, rlast_in;

   logic            cfg_wr;
   logic            cfg_hit;
   logic [2:0]      reg_idx;
   logic [IDXW-1:0] last_part;
   logic [DW-1:0]   extent;
   logic [W-1:0]    prod_lo;
   logic [DW-1:0]   prod_hi;
   logic            item_end;

   logic            done_lo, done_hi;
   logic [W-1:0]    q_lo, r_lo, q_hi, r_hi;

   assign reg_idx = csr_paddr[rbms_pkg::CSR_ADDR_W-1:2];
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_hit = cfg_wr && (reg_idx == rbms_pkg::REG_SPLIT_DIM ||
                               reg_idx == rbms_pkg::REG_PART_COUNT ||
                               reg_idx == rbms_pkg::REG_PART_SIZE_1 ||
                               reg_idx == rbms_pkg::REG_PART_SIZE_2 ||
                               reg_idx == rbms_pkg::REG_PART_SIZE_3);

   always_comb begin
      unique case (reg_idx)
         rbms_pkg::REG_SPLIT_DIM:   csr_prdata = {{(DW-2){1'b0}}, split_dim_ff};
         rbms_pkg::REG_PART_COUNT:  csr_prdata = {{(DW-3){1'b0}}, part_count_ff};
         rbms_pkg::REG_PART_SIZE_1: csr_prdata = part_size1_ff;
         rbms_pkg::REG_PART_SIZE_2: csr_prdata = part_size2_ff;
         rbms_pkg::REG_PART_SIZE_3: csr_prdata = part_size3_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // Index of the last coordinate: a count of zero acts as one, and counts
   // above the table depth are clipped to it.
   always_comb begin
      if (part_count_ff == 3'd0) begin
         last_part = '0;
      end else if (32'(part_count_ff) > MAX_DIM) begin
         last_part = IDXW'(MAX_DIM - 1);
      end else begin
         last_part = IDXW'(part_count_ff - 3'd1);
      end
   end

   // Sub-dimensions without a register have an extent of one.
   always_comb begin
      if (32'(rb_idx_ff) == 1) begin
         extent = part_size1_ff;
      end else if (32'(rb_idx_ff) == 2) begin
         extent = part_size2_ff;
      end else if (32'(rb_idx_ff) == 3) begin
         extent = part_size3_ff;
      end else begin
         extent = DW'(1);
      end
   end

   assign prod_lo = W'(acc_ff[DW-1:0]) * W'(extent);
   assign prod_hi = acc_ff[W-1:DW] * extent;

   assign item_end = cmd.load_pass || (cmd.load_part && status.part_last);

   always_comb begin
      split_dim_in  = split_dim_ff;
      part_count_in = part_count_ff;
      part_size1_in = part_size1_ff;
      part_size2_in = part_size2_ff;
      part_size3_in = part_size3_ff;
      if (cfg_wr) begin
         unique case (reg_idx)
            rbms_pkg::REG_SPLIT_DIM:   split_dim_in  = csr_pwdata[1:0];
            rbms_pkg::REG_PART_COUNT:  part_count_in = csr_pwdata[2:0];
            rbms_pkg::REG_PART_SIZE_1: part_size1_in = csr_pwdata;
            rbms_pkg::REG_PART_SIZE_2: part_size2_in = csr_pwdata;
            rbms_pkg::REG_PART_SIZE_3: part_size3_in = csr_pwdata;
            default: ;
         endcase
      end

      stride_in = stride_ff;
      rb_idx_in = rb_idx_ff;
      acc_in    = acc_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      if (cmd.rb_init) begin
         for (int i = 0; i < MAX_DIM; i++) begin
            stride_in[i] = '1;
         end
         acc_in    = W'(1);
         rb_idx_in = last_part;
      end
      if (cmd.rb_write) begin
         stride_in[rb_idx_ff] = acc_ff;
      end
      if (cmd.rb_mul_lo) begin
         plo_in = prod_lo;
      end
      if (cmd.rb_mul_hi) begin
         phi_in = prod_hi;
      end
      if (cmd.rb_acc) begin
         acc_in    = plo_ff + {phi_ff, {DW{1'b0}}};
         rb_idx_in = rb_idx_ff - IDXW'(1);
      end

      lo_in      = lo_ff;
      hi_in      = hi_ff;
      last_in    = last_ff;
      part_in    = part_ff;
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      rv_in      = rv_ff && rsp_stall;
      ridx_in    = ridx_ff;
      rlo_in     = rlo_ff;
      rhi_in     = rhi_ff;
      rlast_in   = rlast_ff;

      if (cmd.accept) begin
         lo_in   = req_lo_bound;
         hi_in   = req_hi_bound;
         last_in = req_rect_last;
         part_in = '0;
      end
      if (cmd.load_pass) begin
         rv_in      = 1'b1;
         ridx_in    = out_cnt_ff;
         rlo_in     = lo_ff;
         rhi_in     = hi_ff;
         rlast_in   = 1'b1;
         out_cnt_in = out_cnt_ff + 1'b1;
      end
      if (cmd.load_part) begin
         rv_in      = 1'b1;
         ridx_in    = out_cnt_ff;
         rlo_in     = q_lo;
         rhi_in     = q_hi;
         rlast_in   = status.part_last;
         out_cnt_in = out_cnt_ff + 1'b1;
         lo_in      = r_lo;
         hi_in      = r_hi;
         part_in    = part_ff + IDXW'(1);
      end
      if (item_end) begin
         if (last_ff) begin
            in_cnt_in  = '0;
            out_cnt_in = '0;
         end else begin
            in_cnt_in  = in_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_dim_ff  <= 2'd0;
         part_count_ff <= 3'd1;
         part_size1_ff <= DW'(1);
         part_size2_ff <= DW'(1);
         part_size3_ff <= DW'(1);
         in_cnt_ff     <= '0;
         out_cnt_ff    <= '0;
         rv_ff         <= 1'b0;
      end else begin
         split_dim_ff  <= split_dim_in;
         part_count_ff <= part_count_in;
         part_size1_ff <= part_size1_in;
         part_size2_ff <= part_size2_in;
         part_size3_ff <= part_size3_in;
         in_cnt_ff     <= in_cnt_in;
         out_cnt_ff    <= out_cnt_in;
         rv_ff         <= rv_in;
      end
      stride_ff <= stride_in;
      rb_idx_ff <= rb_idx_in;
      acc_ff    <= acc_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      last_ff   <= last_in;
      part_ff   <= part_in;
      ridx_ff   <= ridx_in;
      rlo_ff    <= rlo_in;
      rhi_ff    <= rhi_in;
      rlast_ff  <= rlast_in;
   end

   // Low and high bounds are divided side by side by the same stride.
   rbms_div u_div_lo (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (lo_ff),
      .divisor   (stride_ff[part_ff]),
      .done      (done_lo),
      .quotient  (q_lo),
      .remainder (r_lo)
   );

   rbms_div u_div_hi (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (hi_ff),
      .divisor   (stride_ff[part_ff]),
      .done      (done_hi),
      .quotient  (q_hi),
      .remainder (r_hi)
   );

   always_comb begin
      status.cfg_wr    = cfg_hit;
      status.rb_last   = (rb_idx_ff == '0);
      status.split_hit = ({1'b0, split_dim_ff} == in_cnt_ff);
      status.div_done  = done_lo && done_hi;
      status.out_free  = !rv_ff || !rsp_stall;
      status.part_last = (part_ff == last_part);
   end

   assign rsp_valid     = rv_ff;
   assign rsp_out_index = ridx_ff;
   assign rsp_out_lo    = rlo_ff;
   assign rsp_out_hi    = rhi_ff;
   assign rsp_run_last  = rlast_ff;

endmodule

`default_nettype wire

@@ design/rbms_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbms_ctrl
// Controller: sequences the stride rebuild after reset and register writes,
// and walks each accepted item through pass-through or the division rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module rbms_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rbms_pkg::status_type status,
   output rbms_pkg::cmd_type         cmd
);

   rbms_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbms_pkg::ST_RB_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != rbms_pkg::ST_IDLE) || status.cfg_wr;

      unique case (state_ff)
         rbms_pkg::ST_RB_INIT: begin
            if (status.cfg_wr) begin
               state_in = rbms_pkg::ST_RB_INIT;
            end else begin
               cmd.rb_init = 1'b1;
               state_in    = rbms_pkg::ST_RB_WRITE;
            end
         end
         rbms_pkg::ST_RB_WRITE: begin
            if (status.cfg_wr) begin
               state_in = rbms_pkg::ST_RB_INIT;
            end else begin
               cmd.rb_write = 1'b1;
               state_in = status.rb_last ? rbms_pkg::ST_IDLE : rbms_pkg::ST_RB_MUL_LO;
            end
         end
         rbms_pkg::ST_RB_MUL_LO: begin
            if (status.cfg_wr) begin
               state_in = rbms_pkg::ST_RB_INIT;
            end else begin
               cmd.rb_mul_lo = 1'b1;
               state_in      = rbms_pkg::ST_RB_MUL_HI;
            end
         end
         rbms_pkg::ST_RB_MUL_HI: begin
            if (status.cfg_wr) begin
               state_in = rbms_pkg::ST_RB_INIT;
            end else begin
               cmd.rb_mul_hi = 1'b1;
               state_in      = rbms_pkg::ST_RB_ACC;
            end
         end
         rbms_pkg::ST_RB_ACC: begin
            if (status.cfg_wr) begin
               state_in = rbms_pkg::ST_RB_INIT;
            end else begin
               cmd.rb_acc = 1'b1;
               state_in   = rbms_pkg::ST_RB_WRITE;
            end
         end
         rbms_pkg::ST_IDLE: begin
            if (status.cfg_wr) begin
               state_in = rbms_pkg::ST_RB_INIT;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = status.split_hit ? rbms_pkg::ST_DIV_START : rbms_pkg::ST_PASS;
            end
         end
         rbms_pkg::ST_PASS: begin
            if (status.out_free) begin
               cmd.load_pass = 1'b1;
               state_in      = rbms_pkg::ST_IDLE;
            end
         end
         rbms_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = rbms_pkg::ST_DIV_WAIT;
         end
         rbms_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = rbms_pkg::ST_PART_OUT;
            end
         end
         rbms_pkg::ST_PART_OUT: begin
            if (status.out_free) begin
               cmd.load_part = 1'b1;
               state_in = status.part_last ? rbms_pkg::ST_IDLE : rbms_pkg::ST_DIV_START;
            end
         end
         default: begin
            state_in = rbms_pkg::ST_RB_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire
